### design/vtesc_pkg.sv
package vtesc_pkg;

  localparam int unsigned MaxGroupsDef = 8;
  localparam int unsigned MaxParamsDef = 16;
  localparam int unsigned TextDepthDef = 32;

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChQm    = 8'h3F;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLbrk  = 8'h5B;
  localparam logic [7:0] ChRbrk  = 8'h5D;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChDollar = 8'h24;

  localparam logic [15:0] FinPrint = 16'h00FF;
  localparam logic [15:0] DcsFirst = 16'h0020;
  localparam logic [19:0] WordMax  = 20'h0FFFF;
  localparam logic [3:0]  Ten      = 4'd10;

  typedef enum logic [1:0] {
    KIND_CSI = 2'd0,
    KIND_ESC = 2'd1,
    KIND_OSC = 2'd2,
    KIND_DCS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REC_PRINT = 3'd0,
    REC_ESC   = 3'd1,
    REC_CSI   = 3'd2,
    REC_OSC   = 3'd3,
    REC_DCS   = 3'd4
  } rec_e;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_CSI_CLEAR = 4'd1,
    ACT_EOB_CLR   = 4'd2,
    ACT_EOB_FLUSH = 4'd3,
    ACT_OSC_OPEN  = 4'd4,
    ACT_DCS_OPEN  = 4'd5,
    ACT_DIGIT     = 4'd6,
    ACT_SEP       = 4'd7,
    ACT_INTER     = 4'd8,
    ACT_CSI_FIN   = 4'd9,
    ACT_OSC_DIGIT = 4'd10,
    ACT_OSC_SEMI  = 4'd11,
    ACT_OSC_TEXT  = 4'd12,
    ACT_TEXT      = 4'd13
  } act_e;

  typedef enum logic [1:0] {
    SEL_HEAD = 2'd0,
    SEL_CNT  = 2'd1,
    SEL_PRM  = 2'd2,
    SEL_TXT  = 2'd3
  } sel_e;

  typedef struct packed {
    logic       accept;
    act_e       act;
    rec_e       rec;
    logic       emit;
    sel_e       sel;
    logic [1:0] hidx;
    logic       last;
    logic       walk_init;
    logic       grp_latch;
    logic       grp_next;
    logic       prm_rd;
    logic       prm_step;
    logic       txt_rd;
    logic       txt_step;
    logic       text_clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic osc_done;
    logic txt_empty;
    logic txt_last;
    logic gt_zero;
    logic grp_last;
    logic cnt_zero;
    logic prm_last;
  } stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= Ch0) && (b <= Ch9);
  endfunction

  function automatic logic [19:0] times_ten_plus(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 1) + {16'b0, d};
  endfunction

endpackage

### design/vtesc_if.sv
interface vtesc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface vtesc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] word;
  logic        last;
  modport source (output valid, output record_kind, output word, output last, input ready);
  modport sink (input valid, input record_kind, input word, input last, output ready);
endinterface

### design/vt_escape_sequence_parser.sv
// terminal escape sequence parser
// in_i takes one beat per terminal byte (operation 0) or an end-of-buffer
// marker (operation 1); out_o gives action records as runs of 16-bit words,
// the final word of each record flagged by last.
// each record opens with four header words (first, aux, reserved, count);
// csi records then list each group's count and its parameters, osc and dcs
// records their text bytes.
// a beat that makes no record leaves in_i.ready high for the next beat.
// a beat that makes a record holds in_i low until the record's last word is
// loaded: the beat, then each header or count word, and each parameter or
// text word, which is first read from the parameter or text memory through
// a registered read port and then loaded.
// the output register keeps a word while out_o.ready is low; the walk over
// the record waits and no word is lost.
// reset returns the parser to ground with no sequence pending; the memories
// need no clearing pass since a record only reads entries it wrote.
module vt_escape_sequence_parser #(
  parameter int unsigned MAX_GROUPS = vtesc_pkg::MaxGroupsDef,
  parameter int unsigned MAX_PARAMS = vtesc_pkg::MaxParamsDef,
  parameter int unsigned TEXT_DEPTH = vtesc_pkg::TextDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vtesc_in_if.sink   in_i,
  vtesc_out_if.source out_o
);
  import vtesc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vtesc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.operation),
    .byte_i     (in_i.data_byte),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vtesc_dp #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_PARAMS (MAX_PARAMS),
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (in_i.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_kind_o  (out_o.record_kind),
    .out_word_o  (out_o.word),
    .out_last_o  (out_o.last)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("word loaded over a waiting beat");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !cmd.emit)
    else $error("word emitted while taking input");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> in_i.ready)
    else $error("record end did not return to input");
endmodule

### design/vtesc_ram.sv
module vtesc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### design/vtesc_dp.sv
module vtesc_dp #(
  parameter int unsigned MAX_GROUPS = vtesc_pkg::MaxGroupsDef,
  parameter int unsigned MAX_PARAMS = vtesc_pkg::MaxParamsDef,
  parameter int unsigned TEXT_DEPTH = vtesc_pkg::TextDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  vtesc_pkg::cmd_t    cmd_i,
  output vtesc_pkg::stat_t   stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         out_kind_o,
  output logic [15:0]        out_word_o,
  output logic               out_last_o
);
  import vtesc_pkg::*;

  localparam int unsigned PiW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned PaW = $clog2(MAX_PARAMS);
  localparam int unsigned GtW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned GaW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned TlW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned TaW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

  logic [GtW-1:0] gt_q, gt_d, g_q, g_d, gn;
  logic [PiW-1:0] pni_q, pni_d, pi_q, pi_d, pend_q, pend_d, gend;
  logic           pig_q, pig_d;
  logic [15:0]    acc_q, acc_d;
  logic [7:0]     first_q, first_d;
  logic [1:0]     it_q, it_d;
  logic [15:0]    cmd_q, cmd_d;
  logic           done_q, done_d;
  logic [TlW-1:0] len_q, len_d, ti_q, ti_d;
  logic [7:0]     byte_q;
  logic [PiW-1:0] gs [MAX_GROUPS];

  logic           gs_we;
  logic           p_we, t_we;
  logic [15:0]    p_wdata, p_rdata;
  logic [7:0]     t_rdata;
  logic [19:0]    dig_v, osc_v;
  logic [3:0]     dig;
  logic           zero_new, do_close, pni_room, gt_room;

  logic           ov_q, ov_d, last_q;
  logic [1:0]     kind_q;
  logic [15:0]    word_q, word_d;

  assign dig      = byte_i[3:0];
  assign dig_v    = times_ten_plus(acc_q, dig);
  assign osc_v    = times_ten_plus(cmd_q, dig);
  assign pni_room = pni_q < PiW'(MAX_PARAMS);
  assign gt_room  = gt_q < GtW'(MAX_GROUPS);
  assign zero_new = !pig_q && gt_room && pni_room;

  always_comb begin
    gt_d = gt_q; pni_d = pni_q; pig_d = pig_q; acc_d = acc_q;
    first_d = first_q; it_d = it_q; cmd_d = cmd_q; done_d = done_q; len_d = len_q;
    gs_we = 1'b0; p_we = 1'b0; p_wdata = '0; t_we = 1'b0; do_close = 1'b0;
    if (cmd_i.accept) begin
      case (cmd_i.act)
        ACT_CSI_CLEAR, ACT_EOB_FLUSH: begin
          gt_d = '0; pni_d = '0; pig_d = 1'b0; first_d = '0; it_d = '0;
        end
        ACT_EOB_CLR: begin
          gt_d = '0; pni_d = '0; pig_d = 1'b0; first_d = '0; it_d = '0;
          cmd_d = '0; done_d = 1'b0; len_d = '0;
        end
        ACT_OSC_OPEN: begin
          cmd_d = '0; done_d = 1'b0; len_d = '0;
        end
        ACT_DCS_OPEN: len_d = '0;
        ACT_DIGIT: begin
          if (!pig_q && pni_room) begin
            acc_d = {12'b0, dig}; pig_d = 1'b1; p_we = 1'b1; p_wdata = {12'b0, dig};
          end else if (pig_q) begin
            acc_d = (dig_v > WordMax) ? 16'hFFFF : dig_v[15:0];
            p_we = 1'b1; p_wdata = acc_d;
          end
        end
        ACT_SEP: do_close = 1'b1;
        ACT_CSI_FIN: do_close = pig_q || (gt_q == '0 && pni_room);
        ACT_INTER: begin
          if (it_q != 2'd3) begin
            if (it_q == 2'd0) first_d = byte_i;
            it_d = it_q + 2'd1;
          end
        end
        ACT_OSC_DIGIT: cmd_d = (osc_v > WordMax) ? 16'hFFFF : osc_v[15:0];
        ACT_OSC_SEMI: done_d = 1'b1;
        ACT_OSC_TEXT, ACT_TEXT: begin
          if (cmd_i.act == ACT_OSC_TEXT) done_d = 1'b1;
          if (len_q < TlW'(TEXT_DEPTH)) begin
            t_we = 1'b1; len_d = len_q + TlW'(1);
          end
        end
        default: ;
      endcase
      if (do_close) begin
        // an empty group reads as a single zero
        if (zero_new) begin
          p_we = 1'b1; p_wdata = '0;
        end
        if (gt_room) begin
          gs_we = 1'b1; gt_d = gt_q + GtW'(1);
        end
        pni_d = pni_q + PiW'(pig_q || zero_new);
        pig_d = 1'b0;
      end
    end
    if (cmd_i.text_clear) begin
      cmd_d = '0; done_d = 1'b0; len_d = '0;
    end
  end

  // walk over groups, params and text
  assign gn   = g_q + GtW'(1);
  assign gend = (gn < gt_q) ? gs[gn[GaW-1:0]] : pni_q;

  always_comb begin
    g_d = g_q; pi_d = pi_q; pend_d = pend_q; ti_d = ti_q;
    if (cmd_i.walk_init) begin
      g_d = '0; pi_d = '0; ti_d = '0;
    end
    if (cmd_i.grp_latch) pend_d = gend;
    if (cmd_i.grp_next) g_d = gn;
    if (cmd_i.prm_step) pi_d = pi_q + PiW'(1);
    if (cmd_i.txt_step) ti_d = ti_q + TlW'(1);
  end

  always_comb begin
    word_d = '0;
    case (cmd_i.sel)
      SEL_HEAD: begin
        case (cmd_i.hidx)
          2'd0: begin
            case (cmd_i.rec)
              REC_PRINT: word_d = FinPrint;
              REC_OSC:   word_d = cmd_q;
              REC_DCS:   word_d = DcsFirst;
              default:   word_d = {8'b0, byte_q};
            endcase
          end
          2'd1: begin
            if (cmd_i.rec == REC_PRINT) word_d = {8'b0, byte_q};
            else if (cmd_i.rec == REC_CSI && it_q != 2'd0) word_d = {8'b0, first_q};
          end
          2'd3: begin
            if (cmd_i.rec == REC_CSI) word_d = 16'(gt_q);
            else if (cmd_i.rec == REC_OSC || cmd_i.rec == REC_DCS) word_d = 16'(len_q);
          end
          default: word_d = '0;
        endcase
      end
      SEL_CNT: word_d = 16'(gend - pi_q);
      SEL_PRM: word_d = p_rdata;
      SEL_TXT: word_d = {8'b0, t_rdata};
      default: word_d = '0;
    endcase
  end

  assign ov_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= '0; pni_q <= '0; pig_q <= 1'b0; first_q <= '0; it_q <= '0;
      cmd_q <= '0; done_q <= 1'b0; len_q <= '0; ov_q <= 1'b0;
      g_q <= '0; pi_q <= '0; pend_q <= '0; ti_q <= '0;
    end else begin
      gt_q <= gt_d; pni_q <= pni_d; pig_q <= pig_d; first_q <= first_d; it_q <= it_d;
      cmd_q <= cmd_d; done_q <= done_d; len_q <= len_d; ov_q <= ov_d;
      g_q <= g_d; pi_q <= pi_d; pend_q <= pend_d; ti_q <= ti_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.accept) byte_q <= byte_i;
    if (gs_we) gs[gt_q[GaW-1:0]] <= pni_q;
    if (cmd_i.emit) begin
      word_q <= word_d;
      last_q <= cmd_i.last;
      case (cmd_i.rec)
        REC_ESC: kind_q <= KIND_ESC;
        REC_OSC: kind_q <= KIND_OSC;
        REC_DCS: kind_q <= KIND_DCS;
        default: kind_q <= KIND_CSI;
      endcase
    end
  end

  vtesc_ram #(.Width(16), .Depth(MAX_PARAMS)) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pni_q[PaW-1:0]),
    .wdata_i (p_wdata),
    .re_i    (cmd_i.prm_rd),
    .raddr_i (pi_q[PaW-1:0]),
    .rdata_o (p_rdata)
  );

  vtesc_ram #(.Width(8), .Depth(TEXT_DEPTH)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (len_q[TaW-1:0]),
    .wdata_i (byte_i),
    .re_i    (cmd_i.txt_rd),
    .raddr_i (ti_q[TaW-1:0]),
    .rdata_o (t_rdata)
  );

  assign stat_o.out_free  = !ov_q || out_ready_i;
  assign stat_o.osc_done  = done_q;
  assign stat_o.txt_empty = (len_q == '0);
  assign stat_o.txt_last  = (ti_q + TlW'(1) >= len_q);
  assign stat_o.gt_zero   = (gt_q == '0);
  assign stat_o.grp_last  = (gn >= gt_q);
  assign stat_o.cnt_zero  = (gend == pi_q);
  assign stat_o.prm_last  = (pi_q + PiW'(1) >= pend_q);

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_word_o  = word_q;
  assign out_last_o  = last_q;
endmodule

### design/vtesc_ctrl.sv
module vtesc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             op_i,
  input  logic [7:0]       byte_i,
  output logic             in_ready_o,
  input  vtesc_pkg::stat_t stat_i,
  output vtesc_pkg::cmd_t  cmd_o
);
  import vtesc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HEAD = 7'b0000010,
    S_GRP  = 7'b0000100,
    S_PRD  = 7'b0001000,
    S_PWR  = 7'b0010000,
    S_TRD  = 7'b0100000,
    S_TWR  = 7'b1000000
  } state_e;

  typedef enum logic [4:0] {
    M_GROUND = 5'b00001,
    M_ESC    = 5'b00010,
    M_CSI    = 5'b00100,
    M_OSC    = 5'b01000,
    M_DCS    = 5'b10000
  } mode_e;

  state_e     st_q, st_d;
  mode_e      mode_q, mode_d;
  rec_e       rec_q, rec_d;
  logic [1:0] hw_q, hw_d;
  logic       start;
  logic       accept;
  logic       desig;

  assign in_ready_o = (st_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign desig = (byte_i == ChLpar) || (byte_i == ChRpar) || (byte_i == ChStar) ||
                 (byte_i == ChPlus) || (byte_i == ChDollar) || (byte_i == ChSlash);

  always_comb begin
    st_d = st_q; mode_d = mode_q; rec_d = rec_q; hw_d = hw_q; start = 1'b0;
    cmd_o = '0;
    cmd_o.act  = ACT_NONE;
    cmd_o.rec  = rec_q;
    cmd_o.sel  = SEL_HEAD;
    cmd_o.hidx = hw_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (op_i) begin
            mode_d = M_GROUND;
            if (mode_q == M_OSC && !stat_i.txt_empty) begin
              cmd_o.act = ACT_EOB_FLUSH; rec_d = REC_OSC; start = 1'b1;
            end else begin
              cmd_o.act = ACT_EOB_CLR;
            end
          end else begin
            case (mode_q)
              M_GROUND: begin
                if (byte_i == ChEsc) mode_d = M_ESC;
                else if (byte_i >= ChSpace) begin
                  rec_d = REC_PRINT; start = 1'b1;
                end
              end
              M_ESC: begin
                if (byte_i == ChLbrk) begin
                  cmd_o.act = ACT_CSI_CLEAR; mode_d = M_CSI;
                end else if (byte_i == ChRbrk) begin
                  cmd_o.act = ACT_OSC_OPEN; mode_d = M_OSC;
                end else if (byte_i == ChP || byte_i == ChX || byte_i == ChCaret ||
                             byte_i == ChUnder) begin
                  cmd_o.act = ACT_DCS_OPEN; mode_d = M_DCS;
                end else if (byte_i == ChEsc || desig || byte_i < ChSpace) begin
                  mode_d = M_GROUND;
                end else begin
                  rec_d = REC_ESC; start = 1'b1; mode_d = M_GROUND;
                end
              end
              M_CSI: begin
                if (byte_i == ChEsc) begin
                  cmd_o.act = ACT_CSI_CLEAR; mode_d = M_ESC;
                end else if (is_digit(byte_i)) cmd_o.act = ACT_DIGIT;
                else if (byte_i == ChSemi || byte_i == ChColon) cmd_o.act = ACT_SEP;
                else if ((byte_i >= ChSpace && byte_i <= ChSlash) ||
                         (byte_i >= ChLt && byte_i <= ChQm)) cmd_o.act = ACT_INTER;
                else if (byte_i >= ChAt && byte_i <= ChTilde) begin
                  cmd_o.act = ACT_CSI_FIN; rec_d = REC_CSI; start = 1'b1;
                  mode_d = M_GROUND;
                end
              end
              M_OSC, M_DCS: begin
                if (byte_i == ChEsc || byte_i == ChBel) begin
                  rec_d = (mode_q == M_OSC) ? REC_OSC : REC_DCS; start = 1'b1;
                  mode_d = (byte_i == ChEsc) ? M_ESC : M_GROUND;
                end else if (mode_q == M_OSC && !stat_i.osc_done && is_digit(byte_i)) begin
                  cmd_o.act = ACT_OSC_DIGIT;
                end else if (mode_q == M_OSC && !stat_i.osc_done && byte_i == ChSemi) begin
                  cmd_o.act = ACT_OSC_SEMI;
                end else if (byte_i >= ChSpace) begin
                  cmd_o.act = (mode_q == M_OSC) ? ACT_OSC_TEXT : ACT_TEXT;
                end
              end
              default: mode_d = M_GROUND;
            endcase
          end
          if (start) begin
            cmd_o.walk_init = 1'b1; hw_d = 2'd0; st_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          hw_d = hw_q + 2'd1;
          if (hw_q == 2'd3) begin
            case (rec_q)
              REC_CSI: begin
                if (stat_i.gt_zero) begin
                  cmd_o.last = 1'b1; st_d = S_IDLE;
                end else st_d = S_GRP;
              end
              REC_OSC, REC_DCS: begin
                if (stat_i.txt_empty) begin
                  cmd_o.last = 1'b1; cmd_o.text_clear = 1'b1; st_d = S_IDLE;
                end else st_d = S_TRD;
              end
              default: begin
                cmd_o.last = 1'b1; st_d = S_IDLE;
              end
            endcase
          end
        end
      end
      S_GRP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1; cmd_o.sel = SEL_CNT; cmd_o.grp_latch = 1'b1;
          if (!stat_i.cnt_zero) st_d = S_PRD;
          else if (stat_i.grp_last) begin
            cmd_o.last = 1'b1; st_d = S_IDLE;
          end else cmd_o.grp_next = 1'b1;
        end
      end
      S_PRD: begin
        cmd_o.prm_rd = 1'b1; st_d = S_PWR;
      end
      S_PWR: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1; cmd_o.sel = SEL_PRM; cmd_o.prm_step = 1'b1;
          if (!stat_i.prm_last) st_d = S_PRD;
          else if (stat_i.grp_last) begin
            cmd_o.last = 1'b1; st_d = S_IDLE;
          end else begin
            cmd_o.grp_next = 1'b1; st_d = S_GRP;
          end
        end
      end
      S_TRD: begin
        cmd_o.txt_rd = 1'b1; st_d = S_TWR;
      end
      S_TWR: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1; cmd_o.sel = SEL_TXT; cmd_o.txt_step = 1'b1;
          if (stat_i.txt_last) begin
            cmd_o.last = 1'b1; cmd_o.text_clear = 1'b1; st_d = S_IDLE;
          end else st_d = S_TRD;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      mode_q <= M_GROUND;
      rec_q  <= REC_PRINT;
      hw_q   <= '0;
    end else begin
      st_q   <= st_d;
      mode_q <= mode_d;
      rec_q  <= rec_d;
      hw_q   <= hw_d;
    end
  end
endmodule
